/* hdl/mh64_pkg.sv */
package mh64_pkg;

  localparam logic [63:0] MURMUR_MUL   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MURMUR_SHIFT = 47;

  // Request to the shared multiplier: operand is multiplied by MURMUR_MUL.
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // Byte mask keeping the low n bytes of a word.
  function automatic logic [63:0] tail_mask(input logic [2:0] n);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < n) begin
        m[8*i +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  function automatic logic [63:0] xor_shift(input logic [63:0] v);
    return v ^ (v >> MURMUR_SHIFT);
  endfunction

endpackage

/* hdl/mh64_mul.sv */
module mh64_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mh64_pkg::mul_req_t req_i,
  output mh64_pkg::mul_rsp_t rsp_o
);
  import mh64_pkg::*;

  localparam logic [1:0] LAST_STEP = 2'd2;

  logic [63:0] a_q;
  logic [63:0] acc_q, acc_d;
  logic [1:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [31:0] op_x, op_y;
  logic [63:0] pp;

  // Low 64 bits of a*M from three 32x32 partial products, one per cycle.
  always_comb begin
    op_x = (cnt_q == 2'd1) ? a_q[63:32] : a_q[31:0];
    op_y = (cnt_q == LAST_STEP) ? MURMUR_MUL[63:32] : MURMUR_MUL[31:0];
    pp   = 64'(op_x) * 64'(op_y);
    if (cnt_q == 2'd0) begin
      acc_d = pp;
    end else begin
      acc_d = acc_q + {pp[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.operand;
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

/* hdl/murmur_hash_64_core.sv */
// MurmurHash64A engine for byte messages streamed as 64-bit little-endian
// words (first byte in bits 7:0). A word with first_i set opens a message,
// carries its total byte length on msg_bytes_i (low LENGTH_BITS bits used)
// and its first data word; it aborts any open message without output. Words
// with first_i low and no open message are dropped. The seed is written
// through the cfg port, which is ready only while the core is idle, and
// applies to messages that start afterwards. All multiplications by the
// MurmurHash constant share one 32x32 multiplier that builds each 64-bit
// product from three partial products. A start word costs the length product
// and those of its data word, a full 8-byte word the two word-mix products
// and the accumulator product, the partial tail word the accumulator product
// and the final avalanche one more; in_stall_o is high for all of that time.
// One digest leaves per message through an output register, so the next word
// is taken while a digest still waits on out_stall_i. A zero-length message
// yields its digest after the length product and the avalanche.
module murmur_hash_64_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [31:0] msg_bytes_i,
  input  logic        first_i,
  // digests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] digest_o,
  // seed register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_hash_seed_i
);
  import mh64_pkg::*;

  localparam int unsigned LenInBits = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;

  typedef enum logic [2:0] {
    S_IDLE,  // wait for a word
    S_LEN,   // length times multiplier
    S_K1,    // first product of the word mix
    S_K2,    // second product of the word mix
    S_H,     // accumulator times multiplier
    S_FIN,   // avalanche product
    S_WAIT   // digest ready, output register still full
  } state_e;

  state_e                 state_q, state_d;
  logic [63:0]            seed_q, seed_d;
  logic [63:0]            h_q, h_d;
  logic [63:0]            word_q, word_d;
  logic [63:0]            fin_q, fin_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic                   open_q, open_d;
  logic                   out_valid_q, out_valid_d;
  logic [63:0]            digest_q, digest_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  logic                   in_take;
  logic                   out_free;
  logic [LENGTH_BITS-1:0] len_w;
  logic [63:0]            ab_h;
  logic [63:0]            ab_w;
  logic [63:0]            fin_w;

  mh64_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  // hold off seed writes while the core is busy, which covers the length product that needs the seed
  assign cfg_ready_o = (state_q == S_IDLE);
  assign len_w       = LENGTH_BITS'(msg_bytes_i[LenInBits-1:0]);
  assign fin_w       = xor_shift(mul_rsp.product);

  // Absorb operands: right after the length product the accumulator is
  // seed ^ product and the word is the held start word.
  assign ab_h = (state_q == S_LEN) ? (seed_q ^ mul_rsp.product) : h_q;
  assign ab_w = (state_q == S_LEN) ? word_q : data_word_i;

  always_comb begin
    state_d     = state_q;
    seed_d      = seed_q;
    h_d         = h_q;
    word_d      = word_q;
    fin_d       = fin_q;
    rem_d       = rem_q;
    open_d      = open_q;
    digest_d    = digest_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_req     = '0;

    if (cfg_valid_i && cfg_ready_o) begin
      seed_d = cfg_hash_seed_i;
    end

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          if (first_i) begin
            // open a new message: start with the length product
            word_d          = data_word_i;
            rem_d           = len_w;
            open_d          = 1'b1;
            mul_req.start   = 1'b1;
            mul_req.operand = 64'(len_w);
            state_d         = S_LEN;
          end else if (open_q) begin
            mul_req.start = 1'b1;
            if (rem_q[LENGTH_BITS-1:3] != '0) begin
              mul_req.operand = ab_w;
              rem_d           = rem_q - LENGTH_BITS'(8);
              state_d         = S_K1;
            end else begin
              h_d             = ab_h ^ (ab_w & tail_mask(rem_q[2:0]));
              mul_req.operand = ab_h ^ (ab_w & tail_mask(rem_q[2:0]));
              rem_d           = '0;
              state_d         = S_H;
            end
          end
        end
      end
      S_LEN: begin
        if (mul_rsp.done) begin
          h_d           = ab_h;
          mul_req.start = 1'b1;
          if (rem_q == '0) begin
            // empty message: straight to the avalanche
            mul_req.operand = xor_shift(ab_h);
            open_d          = 1'b0;
            state_d         = S_FIN;
          end else if (rem_q[LENGTH_BITS-1:3] != '0) begin
            mul_req.operand = ab_w;
            rem_d           = rem_q - LENGTH_BITS'(8);
            state_d         = S_K1;
          end else begin
            mul_req.operand = ab_h ^ (ab_w & tail_mask(rem_q[2:0]));
            rem_d           = '0;
            state_d         = S_H;
          end
        end
      end
      S_K1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = fin_w;
          state_d         = S_K2;
        end
      end
      S_K2: begin
        if (mul_rsp.done) begin
          h_d             = h_q ^ mul_rsp.product;
          mul_req.start   = 1'b1;
          mul_req.operand = h_q ^ mul_rsp.product;
          state_d         = S_H;
        end
      end
      S_H: begin
        if (mul_rsp.done) begin
          h_d = mul_rsp.product;
          if (rem_q == '0) begin
            mul_req.start   = 1'b1;
            mul_req.operand = fin_w;
            open_d          = 1'b0;
            state_d         = S_FIN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FIN: begin
        if (mul_rsp.done) begin
          if (out_free) begin
            digest_d    = fin_w;
            out_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            fin_d   = fin_w;
            state_d = S_WAIT;
          end
        end
      end
      S_WAIT: begin
        if (out_free) begin
          digest_d    = fin_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seed_q      <= '0;
      rem_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seed_q      <= seed_d;
      rem_q       <= rem_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    h_q      <= h_d;
    word_q   <= word_d;
    fin_q    <= fin_d;
    digest_q <= digest_d;
  end

  assign out_valid_o = out_valid_q;
  assign digest_o    = digest_q;

endmodule
